FILE: design/assert_macros.svh
// assertion macros shared by the design files
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: design/plqm_pkg.sv
// package for the link quality monitor: fixed widths, constants, payload types
// no dependencies
`timescale 1ns / 1ps
package plqm_pkg;
  localparam int SeqW = 16;
  localparam int RssiW = 8;
  localparam int IntW = 24;
  localparam int BinW = 3;
  localparam int NBins = 6;
  localparam int BurstW = 16;
  localparam int PmW = 14;
  localparam int RssiAccW = 48;
  localparam int DevAccW = 64;
  localparam logic [15:0] GapLimit = 16'd1000;
  localparam logic [23:0] IntReset = 24'd1000;
  localparam logic FuncArrive = 1'b0;
  localparam logic FuncRead = 1'b1;
endpackage

FILE: design/plqm_if.sv
// valid/ready channel interfaces for input items and result items
// depends on plqm_pkg
`timescale 1ns / 1ps
interface plqm_in_if import plqm_pkg::*; #(parameter int TW = 48) ();
  logic valid;
  logic ready;
  logic func;
  logic [SeqW-1:0] seq;
  logic [RssiW-1:0] rssi;
  logic [TW-1:0] arrival_us;
  logic [BinW-1:0] bin_select;
  modport source (output valid, func, seq, rssi, arrival_us, bin_select, input ready);
  modport sink (input valid, func, seq, rssi, arrival_us, bin_select, output ready);
endinterface

interface plqm_out_if import plqm_pkg::*; #(parameter int TW = 48, parameter int CW = 32) ();
  logic valid;
  logic ready;
  logic stats_valid;
  logic [CW-1:0] packet_count;
  logic [CW-1:0] lost_count;
  logic [BurstW-1:0] longest_burst;
  logic [PmW-1:0] loss_ratio;
  logic [RssiW-1:0] average_rssi;
  logic [TW-1:0] deviation_min;
  logic [TW-1:0] deviation_avg;
  logic [TW-1:0] deviation_max;
  logic [CW-1:0] bin_count;
  modport source (output valid, stats_valid, packet_count, lost_count, longest_burst,
                  loss_ratio, average_rssi, deviation_min, deviation_avg,
                  deviation_max, bin_count, input ready);
  modport sink (input valid, stats_valid, packet_count, lost_count, longest_burst,
                loss_ratio, average_rssi, deviation_min, deviation_avg,
                deviation_max, bin_count, output ready);
endinterface

FILE: design/plqm_div.sv
// shared restoring divider, one quotient bit per cycle
// depends on plqm_pkg
`timescale 1ns / 1ps
module plqm_div import plqm_pkg::*; #(
  parameter int W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] num_i,
  input  logic [W-1:0] den_i,
  output logic         done_o,
  output logic [W-1:0] quo_o
);
  localparam int CntW = $clog2(W + 1);
  logic [W-1:0] rem_q, rem_d, quo_q, quo_d, den_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [W:0] trial;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q, quo_q[W-1]} - {1'b0, den_q};
    if (start_i) begin
      rem_d = '0;
      quo_d = num_i;
      cnt_d = CntW'(W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[W-2:0], quo_q[W-1]};
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) den_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o = quo_q;
endmodule

FILE: design/plqm_front.sv
// front end: accepts items, updates statistics state, queues a snapshot
// depends on plqm_pkg, plqm_if
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plqm_front import plqm_pkg::*; #(
  parameter int TW = 48,
  parameter int CW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IntW-1:0] interval_i,
  plqm_in_if.sink         in_if,
  output logic            snap_valid_o,
  input  logic            snap_ready_i,
  output logic [CW-1:0]   recv_o,
  output logic [CW-1:0]   lost_o,
  output logic [BurstW-1:0] burst_o,
  output logic [RssiAccW-1:0] rssi_acc_o,
  output logic [TW-1:0]   dmin_o,
  output logic [TW-1:0]   dmax_o,
  output logic [DevAccW-1:0] dacc_o,
  output logic [CW-1:0]   dsamp_o,
  output logic [CW-1:0]   bin_o
);
  localparam logic [CW-1:0] CMax = '1;
  logic [SeqW-1:0] pseq_q;
  logic have_t_q;
  logic [TW-1:0] ptime_q;
  logic [CW-1:0] recv_q, lost_q, dsamp_q;
  logic [BurstW-1:0] cburst_q, mburst_q;
  logic [RssiAccW-1:0] racc_q;
  logic [TW-1:0] dmin_q, dmax_q;
  logic [DevAccW-1:0] dacc_q;
  logic [CW-1:0] hist_q [NBins];
  logic [BinW-1:0] bsel_q;
  logic snap_q;

  logic [SeqW-1:0] expect_s, gap;
  logic [TW-1:0] delta, dev;
  logic [BinW-1:0] bin;
  logic [CW:0] lsum;
  logic [BurstW:0] bsum;
  logic [BurstW-1:0] nburst;
  logic [RssiAccW:0] rsum;
  logic [DevAccW:0] dsum;
  logic take;

  // single-entry snapshot queue: accept when it is empty or draining
  assign in_if.ready = !snap_q || snap_ready_i;
  assign take = in_if.valid && in_if.ready;

  always_comb begin
    expect_s = pseq_q + 1'b1;
    gap = in_if.seq - expect_s;
    lsum = {1'b0, lost_q} + (CW+1)'(gap);
    bsum = {1'b0, cburst_q} + {1'b0, gap};
    nburst = bsum[BurstW] ? '1 : bsum[BurstW-1:0];
    rsum = {1'b0, racc_q} + (RssiAccW+1)'(in_if.rssi);
    delta = in_if.arrival_us - ptime_q;
    dev = (delta >= TW'(interval_i)) ? delta - TW'(interval_i) : TW'(interval_i) - delta;
    dsum = {1'b0, dacc_q} + (DevAccW+1)'(dev);
    if (dev < TW'(100)) bin = 3'd0;
    else if (dev < TW'(500)) bin = 3'd1;
    else if (dev < TW'(1000)) bin = 3'd2;
    else if (dev < TW'(5000)) bin = 3'd3;
    else if (dev < TW'(10000)) bin = 3'd4;
    else bin = 3'd5;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pseq_q <= '0; have_t_q <= 1'b0; ptime_q <= '0;
      recv_q <= '0; lost_q <= '0; cburst_q <= '0; mburst_q <= '0;
      racc_q <= '0; dmin_q <= '1; dmax_q <= '0; dacc_q <= '0; dsamp_q <= '0;
      for (int i = 0; i < NBins; i++) hist_q[i] <= '0;
      snap_q <= 1'b0;
      bsel_q <= '0;
    end else begin
      if (snap_q && snap_ready_i && !take) snap_q <= 1'b0;
      if (take) begin
        snap_q <= 1'b1;
        bsel_q <= in_if.bin_select;
        if (in_if.func == FuncArrive) begin
          if (in_if.seq != expect_s && pseq_q != '0) begin
            if (gap < GapLimit) begin
              lost_q <= lsum[CW] ? CMax : lsum[CW-1:0];
              cburst_q <= nburst;
              if (nburst > mburst_q) mburst_q <= nburst;
            end
          end else begin
            cburst_q <= '0;
          end
          pseq_q <= in_if.seq;
          if (recv_q != CMax) recv_q <= recv_q + 1'b1;
          racc_q <= rsum[RssiAccW] ? '1 : rsum[RssiAccW-1:0];
          if (have_t_q) begin
            if (dev < dmin_q) dmin_q <= dev;
            if (dev > dmax_q) dmax_q <= dev;
            dacc_q <= dsum[DevAccW] ? '1 : dsum[DevAccW-1:0];
            if (dsamp_q != CMax) dsamp_q <= dsamp_q + 1'b1;
            if (hist_q[bin] != CMax) hist_q[bin] <= hist_q[bin] + 1'b1;
          end
          have_t_q <= 1'b1;
          ptime_q <= in_if.arrival_us;
        end
      end
    end
  end

  // state only changes when a snapshot is taken, so the queue reads it live
  assign snap_valid_o = snap_q;
  assign recv_o = recv_q;
  assign lost_o = lost_q;
  assign burst_o = mburst_q;
  assign rssi_acc_o = racc_q;
  assign dmin_o = dmin_q;
  assign dmax_o = dmax_q;
  assign dacc_o = dacc_q;
  assign dsamp_o = dsamp_q;
  assign bin_o = (bsel_q < BinW'(NBins)) ? hist_q[bsel_q] : '0;

  `ASSERT_NEXT(a_take_snap, clk_i, rst_ni, take, snap_q)
  `ASSERT_IMPL(a_ready_q, clk_i, rst_ni, !snap_q, in_if.ready)
  `ASSERT_NEXT(a_burst_max, clk_i, rst_ni, 1'b1, cburst_q <= mburst_q || cburst_q == '0)
endmodule

FILE: design/plqm_back.sv
// back end: up to three divisions on the shared divider, then the result register
// depends on plqm_pkg, plqm_if, plqm_div
`timescale 1ns / 1ps
`include "assert_macros.svh"
module plqm_back import plqm_pkg::*; #(
  parameter int TW = 48,
  parameter int CW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            snap_valid_i,
  output logic            snap_ready_o,
  input  logic [CW-1:0]   recv_i,
  input  logic [CW-1:0]   lost_i,
  input  logic [BurstW-1:0] burst_i,
  input  logic [RssiAccW-1:0] rssi_acc_i,
  input  logic [TW-1:0]   dmin_i,
  input  logic [TW-1:0]   dmax_i,
  input  logic [DevAccW-1:0] dacc_i,
  input  logic [CW-1:0]   dsamp_i,
  input  logic [CW-1:0]   bin_i,
  plqm_out_if.source      out_if
);
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_LOSS, S_RSSI, S_DEV, S_OUT} state_e;
  state_e state_q;
  logic start_q;
  logic [DevAccW-1:0] num_q, den_q, quo;
  logic [CW:0] total_q;
  logic [CW+13:0] prod_q;
  logic done;
  logic dev_done;
  localparam logic [TW-1:0] TMax = '1;

  plqm_div #(.W(DevAccW)) u_div (
    .clk_i, .rst_ni, .start_i(start_q), .num_i(num_q), .den_i(den_q),
    .done_o(done), .quo_o(quo)
  );

  assign dev_done = (dsamp_i == '0) || done;
  // the snapshot is free once the result register loads
  assign snap_ready_o = (state_q == S_DEV) && dev_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      start_q <= 1'b0;
      out_if.valid <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          start_q <= 1'b0;
          if (snap_valid_i) begin
            total_q <= {1'b0, recv_i} + {1'b0, lost_i};
            prod_q <= (CW+14)'(lost_i) * (CW+14)'(10000);
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (total_q == '0) begin
            out_if.loss_ratio <= '0;
            num_q <= DevAccW'(rssi_acc_i);
            den_q <= DevAccW'(recv_i);
            start_q <= (recv_i != '0);
            state_q <= S_RSSI;
            if (recv_i == '0) out_if.average_rssi <= '0;
          end else begin
            num_q <= DevAccW'(prod_q);
            den_q <= DevAccW'(total_q);
            start_q <= 1'b1;
            state_q <= S_LOSS;
          end
        end
        S_LOSS: begin
          if (done) begin
            out_if.loss_ratio <= quo[PmW-1:0];
            num_q <= DevAccW'(rssi_acc_i);
            den_q <= DevAccW'(recv_i);
            start_q <= 1'b1;
            state_q <= S_RSSI;
          end else start_q <= 1'b0;
        end
        S_RSSI: begin
          if (recv_i == '0 || done) begin
            if (recv_i != '0) out_if.average_rssi <= (quo > 64'd255) ? 8'd255 : quo[7:0];
            num_q <= dacc_i;
            den_q <= DevAccW'(dsamp_i);
            start_q <= (dsamp_i != '0);
            state_q <= S_DEV;
          end else start_q <= 1'b0;
        end
        S_DEV: begin
          start_q <= 1'b0;
          if (dev_done) begin
            if (dsamp_i == '0) out_if.deviation_avg <= '0;
            else out_if.deviation_avg <= (quo > DevAccW'(TMax)) ? TMax : quo[TW-1:0];
            out_if.stats_valid <= recv_i != '0;
            out_if.packet_count <= recv_i;
            out_if.lost_count <= lost_i;
            out_if.longest_burst <= burst_i;
            out_if.deviation_min <= (dsamp_i != '0) ? dmin_i : '0;
            out_if.deviation_max <= dmax_i;
            out_if.bin_count <= bin_i;
            out_if.valid <= 1'b1;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          start_q <= 1'b0;
          if (out_if.ready) begin
            out_if.valid <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: begin
          start_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `ASSERT_IMPL(a_valid_out, clk_i, rst_ni, out_if.valid, state_q == S_OUT)
  `ASSERT_IMPL(a_snap_held, clk_i, rst_ni, state_q != S_IDLE && state_q != S_OUT, snap_valid_i)
endmodule

FILE: design/packet_link_quality_monitor.sv
// top level of the packet link quality monitor
// depends on plqm_pkg, plqm_if, plqm_front, plqm_back, plqm_div
`timescale 1ns / 1ps
// Each item runs through three 64-bit divisions (loss ratio, average rssi,
// average deviation), one after another on one shared divider at one quotient
// bit per cycle, after setup in the S_IDLE and S_MUL states; a division whose
// divisor is zero is skipped. The snapshot is freed as the result register
// loads, so the front end takes one more item while a result waits; that item
// starts once the result leaves. No clearing pass after reset.
module packet_link_quality_monitor import plqm_pkg::*; #(
  parameter int TIME_WIDTH = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [IntW-1:0] cfg_wdata_i,
  plqm_in_if.sink         in_if,
  plqm_out_if.source      out_if
);
  logic [IntW-1:0] interval_q;
  logic snap_valid, snap_ready;
  logic [COUNT_WIDTH-1:0] recv, lost, dsamp, bin;
  logic [BurstW-1:0] burst;
  logic [RssiAccW-1:0] racc;
  logic [TIME_WIDTH-1:0] dmin, dmax;
  logic [DevAccW-1:0] dacc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) interval_q <= IntReset;
    else if (cfg_we_i) interval_q <= cfg_wdata_i;
  end

  plqm_front #(.TW(TIME_WIDTH), .CW(COUNT_WIDTH)) u_front (
    .clk_i, .rst_ni, .interval_i(interval_q), .in_if,
    .snap_valid_o(snap_valid), .snap_ready_i(snap_ready),
    .recv_o(recv), .lost_o(lost), .burst_o(burst), .rssi_acc_o(racc),
    .dmin_o(dmin), .dmax_o(dmax), .dacc_o(dacc), .dsamp_o(dsamp), .bin_o(bin)
  );

  plqm_back #(.TW(TIME_WIDTH), .CW(COUNT_WIDTH)) u_back (
    .clk_i, .rst_ni, .snap_valid_i(snap_valid), .snap_ready_o(snap_ready),
    .recv_i(recv), .lost_i(lost), .burst_i(burst), .rssi_acc_i(racc),
    .dmin_i(dmin), .dmax_i(dmax), .dacc_i(dacc), .dsamp_i(dsamp), .bin_i(bin),
    .out_if
  );
endmodule

FILE: test/tb_packet_link_quality_monitor.sv
// testbench for packet_link_quality_monitor: directed table, then random packet streams
// depends on plqm_pkg, plqm_if and the design files; checks every result against a predictor or a typed expectation
`timescale 1ns / 1ps
module tb_packet_link_quality_monitor;
  import plqm_pkg::*;

  localparam int TimeW = 48;
  localparam int CntW = 32;
  localparam int WatchLimit = 10000;
  localparam int HoldCycles = 1500;
  localparam logic [TimeW-1:0] TimeMask = {TimeW{1'b1}};
  localparam logic [63:0] CntCap = 64'hFFFF_FFFF;
  localparam logic [63:0] BurstCap = 64'hFFFF;
  localparam logic [63:0] RssiCap = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] DevCap = {64{1'b1}};

  typedef struct packed {
    logic             stats_valid;
    logic [CntW-1:0]  packet_count;
    logic [CntW-1:0]  lost_count;
    logic [BurstW-1:0] longest_burst;
    logic [PmW-1:0]   loss_ratio;
    logic [RssiW-1:0] average_rssi;
    logic [TimeW-1:0] deviation_min;
    logic [TimeW-1:0] deviation_avg;
    logic [TimeW-1:0] deviation_max;
    logic [CntW-1:0]  bin_count;
  } stats_t;

  typedef struct {
    logic             func;
    logic [SeqW-1:0]  seq;
    logic [RssiW-1:0] rssi;
    logic [TimeW-1:0] arrival;
    logic [BinW-1:0]  bin;
    bit               typed;
    stats_t           stats;
  } packet_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [IntW-1:0] cfg_wdata_i = '0;

  plqm_in_if #(.TW(TimeW)) in_ch ();
  plqm_out_if #(.TW(TimeW), .CW(CntW)) out_ch ();

  packet_link_quality_monitor #(.TIME_WIDTH(TimeW), .COUNT_WIDTH(CntW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_ch),
    .out_if      (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [IntW-1:0]     interval_q;
  logic [SeqW-1:0]     prev_seq_m;
  bit                  have_time;
  logic [TimeW-1:0]    prev_time_m;
  logic [CntW-1:0]     rx_total, lost_total;
  logic [BurstW-1:0]   burst_now, burst_peak;
  logic [RssiAccW-1:0] rssi_acc_m;
  logic [TimeW-1:0]    dev_lo, dev_hi;
  logic [DevAccW-1:0]  dev_sum;
  logic [CntW-1:0]     dev_n;
  logic [CntW-1:0]     dev_hist [NBins];

  stats_t stats_q [$];
  int errors = 0;
  int hold_req = 0;
  bit in_acc, out_acc;
  packet_row_t rows [$];

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, logic [63:0] cap);
    if (a >= cap || b > cap - a) return cap;
    return a + b;
  endfunction

  task automatic predict_stats(input packet_row_t r, output stats_t s);
    logic [SeqW-1:0] nxt, gap;
    logic [TimeW-1:0] delta, dev, ival;
    logic [63:0] total, quo;
    int b;
    if (r.func == FuncArrive) begin
      nxt = prev_seq_m + 1'b1;
      if (r.seq != nxt && prev_seq_m != '0) begin
        gap = r.seq - nxt;
        if (gap < GapLimit) begin
          lost_total = CntW'(sat_add(64'(lost_total), 64'(gap), CntCap));
          burst_now = BurstW'(sat_add(64'(burst_now), 64'(gap), BurstCap));
          if (burst_now > burst_peak) burst_peak = burst_now;
        end
      end else begin
        burst_now = '0;
      end
      prev_seq_m = r.seq;
      rx_total = CntW'(sat_add(64'(rx_total), 64'd1, CntCap));
      rssi_acc_m = RssiAccW'(sat_add(64'(rssi_acc_m), 64'(r.rssi), RssiCap));
      if (have_time) begin
        ival = TimeW'(interval_q);
        delta = r.arrival - prev_time_m;
        dev = (delta >= ival) ? delta - ival : ival - delta;
        if (dev < dev_lo) dev_lo = dev;
        if (dev > dev_hi) dev_hi = dev;
        dev_sum = sat_add(dev_sum, 64'(dev), DevCap);
        dev_n = CntW'(sat_add(64'(dev_n), 64'd1, CntCap));
        if (dev < 100) b = 0;
        else if (dev < 500) b = 1;
        else if (dev < 1000) b = 2;
        else if (dev < 5000) b = 3;
        else if (dev < 10000) b = 4;
        else b = 5;
        dev_hist[b] = CntW'(sat_add(64'(dev_hist[b]), 64'd1, CntCap));
      end
      have_time = 1'b1;
      prev_time_m = r.arrival;
    end
    total = 64'(rx_total) + 64'(lost_total);
    s.stats_valid = rx_total != '0;
    s.packet_count = rx_total;
    s.lost_count = lost_total;
    s.longest_burst = burst_peak;
    s.loss_ratio = (total != 0) ? PmW'((64'(lost_total) * 64'd10000) / total) : '0;
    quo = (rx_total != '0) ? 64'(rssi_acc_m) / 64'(rx_total) : 64'd0;
    s.average_rssi = (quo > 255) ? 8'd255 : quo[7:0];
    s.deviation_min = (dev_n != '0) ? dev_lo : '0;
    quo = (dev_n != '0) ? dev_sum / 64'(dev_n) : 64'd0;
    s.deviation_avg = (quo > 64'(TimeMask)) ? TimeMask : quo[TimeW-1:0];
    s.deviation_max = dev_hi;
    s.bin_count = (r.bin < NBins) ? dev_hist[r.bin] : '0;
  endtask

  // one item offered until taken, then an optional gap
  task automatic send_packet(input packet_row_t r, input int gap_cycles);
    stats_t s;
    in_ch.valid <= 1'b1;
    in_ch.func <= r.func;
    in_ch.seq <= r.seq;
    in_ch.rssi <= r.rssi;
    in_ch.arrival_us <= r.arrival;
    in_ch.bin_select <= r.bin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_stats(r, s);
    stats_q.push_back(r.typed ? r.stats : s);
    if (gap_cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk_i);
    end
  endtask

  task automatic write_interval(input logic [IntW-1:0] v);
    in_ch.valid <= 1'b0;
    wait (stats_q.size() == 0);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    interval_q = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_row(logic func, logic [SeqW-1:0] seq, logic [RssiW-1:0] rssi,
                                  logic [TimeW-1:0] arrival, logic [BinW-1:0] bin);
    packet_row_t r;
    r.func = func; r.seq = seq; r.rssi = rssi; r.arrival = arrival; r.bin = bin;
    r.typed = 1'b0; r.stats = '0;
    rows.push_back(r);
  endfunction

  // receiver: stall pattern, long hold-off on request, check on every taken item
  initial begin
    stats_t got, want;
    int mode, tick;
    out_ch.ready <= 1'b0;
    mode = 0;
    tick = 0;
    forever begin
      @(posedge clk_i);
      out_acc = out_ch.valid && out_ch.ready;
      if (out_acc) begin
        got.stats_valid = out_ch.stats_valid;
        got.packet_count = out_ch.packet_count;
        got.lost_count = out_ch.lost_count;
        got.longest_burst = out_ch.longest_burst;
        got.loss_ratio = out_ch.loss_ratio;
        got.average_rssi = out_ch.average_rssi;
        got.deviation_min = out_ch.deviation_min;
        got.deviation_avg = out_ch.deviation_avg;
        got.deviation_max = out_ch.deviation_max;
        got.bin_count = out_ch.bin_count;
        if (stats_q.size() == 0) begin
          $error("result item with nothing expected");
          errors++;
        end else begin
          want = stats_q.pop_front();
          if (got.stats_valid !== want.stats_valid) begin
            $error("stats_valid exp %0d got %0d", want.stats_valid, got.stats_valid); errors++;
          end
          if (got.packet_count !== want.packet_count) begin
            $error("packet_count exp %0d got %0d", want.packet_count, got.packet_count); errors++;
          end
          if (got.lost_count !== want.lost_count) begin
            $error("lost_count exp %0d got %0d", want.lost_count, got.lost_count); errors++;
          end
          if (got.longest_burst !== want.longest_burst) begin
            $error("longest_burst exp %0d got %0d", want.longest_burst, got.longest_burst);
            errors++;
          end
          if (got.loss_ratio !== want.loss_ratio) begin
            $error("loss_ratio exp %0d got %0d", want.loss_ratio, got.loss_ratio);
            errors++;
          end
          if (got.average_rssi !== want.average_rssi) begin
            $error("average_rssi exp %0d got %0d", want.average_rssi, got.average_rssi); errors++;
          end
          if (got.deviation_min !== want.deviation_min) begin
            $error("deviation_min exp %0d got %0d", want.deviation_min, got.deviation_min);
            errors++;
          end
          if (got.deviation_avg !== want.deviation_avg) begin
            $error("deviation_avg exp %0d got %0d", want.deviation_avg, got.deviation_avg);
            errors++;
          end
          if (got.deviation_max !== want.deviation_max) begin
            $error("deviation_max exp %0d got %0d", want.deviation_max, got.deviation_max);
            errors++;
          end
          if (got.bin_count !== want.bin_count) begin
            $error("bin_count exp %0d got %0d", want.bin_count, got.bin_count); errors++;
          end
        end
      end
      if (hold_req > 0) begin
        out_ch.ready <= 1'b0;
        hold_req--;
      end else begin
        if (tick == 0) begin
          mode = $urandom_range(0, 3);
          tick = $urandom_range(20, 400);
        end
        tick--;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= 1'($urandom_range(0, 1));
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (tick % 7) < 2;
        endcase
      end
    end
  end

  // watchdog on cycles with no item taken on either side
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk_i);
      in_acc = in_ch.valid && in_ch.ready;
      if (in_acc || (out_ch.valid && out_ch.ready)) idle = 0;
      else idle++;
      if (idle >= WatchLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // sender
  initial begin
    packet_row_t r;
    logic [IntW-1:0] phase_int [4];
    logic [SeqW-1:0] seq_d;
    logic [TimeW-1:0] t_d, jit;
    int burst_left, pick;
    in_ch.valid <= 1'b0;
    in_ch.func <= FuncArrive;
    in_ch.seq <= '0;
    in_ch.rssi <= '0;
    in_ch.arrival_us <= '0;
    in_ch.bin_select <= '0;

    interval_q = IntReset;
    prev_seq_m = '0; have_time = 1'b0; prev_time_m = '0;
    rx_total = '0; lost_total = '0; burst_now = '0; burst_peak = '0;
    rssi_acc_m = '0; dev_lo = TimeMask; dev_hi = '0; dev_sum = '0; dev_n = '0;
    for (int i = 0; i < NBins; i++) dev_hist[i] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed table at the reset interval of 1000 us
    add_row(FuncRead, 16'd0, 8'd0, 48'd0, 3'd0);
    rows[0].typed = 1'b1;
    add_row(FuncArrive, 16'd5, 8'd200, 48'd0, 3'd0);
    rows[1].typed = 1'b1;
    rows[1].stats.stats_valid = 1'b1;
    rows[1].stats.packet_count = CntW'(1);
    rows[1].stats.average_rssi = 8'd200;
    add_row(FuncArrive, 16'd6, 8'd0, 48'd1000, 3'd0);      // in order, zero deviation
    add_row(FuncArrive, 16'd9, 8'd17, 48'd2100, 3'd1);     // small gap
    add_row(FuncArrive, 16'd10, 8'd90, 48'd3600, 3'd2);
    add_row(FuncArrive, 16'd2000, 8'd33, 48'd5600, 3'd3);  // large gap ignored
    add_row(FuncArrive, 16'd2001, 8'd1, 48'd11600, 3'd4);
    add_row(FuncArrive, 16'd2002, 8'd255, 48'd22600, 3'd5);
    add_row(FuncRead, 16'hFFFF, 8'hFF, TimeMask, 3'd6);     // out-of-range bins
    add_row(FuncRead, 16'h1234, 8'h55, 48'h0, 3'd7);
    add_row(FuncArrive, 16'hFFFF, 8'd80, 48'h10, 3'd5);
    add_row(FuncArrive, 16'h0000, 8'd80, TimeMask, 3'd2);   // seq wraps, time at its maximum
    add_row(FuncArrive, 16'd3, 8'd70, 48'd400, 3'd0);       // previous seq zero, no check
    add_row(FuncArrive, 16'd5, 8'd70, 48'd1400, 3'd0);
    add_row(FuncArrive, 16'd7, 8'd70, 48'd2400, 3'd0);
    add_row(FuncArrive, 16'd8, 8'd70, 48'd3390, 3'd0);
    add_row(FuncArrive, 16'd1009, 8'd70, 48'd4390, 3'd1);   // gap of exactly the limit
    add_row(FuncArrive, 16'd2009, 8'd70, 48'd5390, 3'd1);   // gap just under the limit
    add_row(FuncRead, 16'd0, 8'd0, 48'd0, 3'd3);
    foreach (rows[i]) send_packet(rows[i], $urandom_range(0, 1) ? 0 : $urandom_range(1, 5));

    phase_int[0] = IntReset;
    phase_int[1] = '0;
    phase_int[2] = {IntW{1'b1}};
    phase_int[3] = IntW'($urandom_range(1, 24'hFFFFFF));
    seq_d = 16'd2009;
    t_d = 48'd5390;
    burst_left = 0;
    for (int ph = 0; ph < 4; ph++) begin
      write_interval(phase_int[ph]);
      for (int k = 0; k < 175; k++) begin
        if (ph == 1 && k == 50) hold_req = HoldCycles;
        if (ph == 2 && k == 30) begin
          in_ch.valid <= 1'b0;
          wait (stats_q.size() == 0);
          @(posedge clk_i);
        end
        pick = $urandom_range(0, 99);
        r.typed = 1'b0;
        r.stats = '0;
        r.rssi = RssiW'($urandom_range(0, 255));
        r.bin = BinW'($urandom_range(0, 7));
        if (pick < 10) begin
          r.func = FuncRead;
          r.seq = SeqW'($urandom);
          r.arrival = TimeW'({$urandom, $urandom});
        end else if (pick < 20) begin
          r.func = FuncArrive;
          r.seq = SeqW'($urandom);
          r.arrival = TimeW'({$urandom, $urandom});
          seq_d = r.seq;
          t_d = r.arrival;
        end else begin
          r.func = FuncArrive;
          case ($urandom_range(0, 9))
            0, 1: seq_d = seq_d + 16'($urandom_range(2, 8));
            2: seq_d = seq_d + 16'($urandom_range(900, 1100));
            default: seq_d = seq_d + 1'b1;
          endcase
          case ($urandom_range(0, 4))
            0: jit = TimeW'($urandom_range(0, 120));
            1: jit = TimeW'($urandom_range(0, 1200));
            2: jit = TimeW'($urandom_range(0, 6000));
            3: jit = TimeW'($urandom_range(0, 30000));
            default: jit = TimeW'({$urandom, $urandom});
          endcase
          t_d = $urandom_range(0, 1) ? t_d + TimeW'(interval_q) + jit
                                     : t_d + TimeW'(interval_q) - jit;
          r.seq = seq_d;
          r.arrival = t_d;
        end
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          send_packet(r, $urandom_range(0, 3) == 0 ? $urandom_range(1, 300) : 0);
        end else begin
          burst_left--;
          send_packet(r, 0);
        end
      end
    end
    in_ch.valid <= 1'b0;

    wait (stats_q.size() == 0);
    repeat (400) @(posedge clk_i);
    if (errors == 0 && stats_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
